[rtl/core/oblu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oblu_pkg: shared types and constants of the order book level update block
// Action and status codes, field widths, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package oblu_pkg;

	localparam int TableDepthDefault = 1024;
	localparam int PriceW = 48;
	localparam int QtyW   = 48;
	localparam int IdW    = 64;
	localparam int RidxW  = 10;
	localparam int CountW = 11;

	typedef enum logic [2:0] {
		ACT_CLEAR     = 3'd0,
		ACT_SNAP_LVL  = 3'd1,
		ACT_SNAP_DONE = 3'd2,
		ACT_EVT_START = 3'd3,
		ACT_EVT_LVL   = 3'd4,
		ACT_READ      = 3'd5,
		ACT_RSV6      = 3'd6,
		ACT_RSV7      = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DROPPED = 3'd1,
		ST_IGNORED = 3'd2,
		ST_FULL    = 3'd3,
		ST_RANGE   = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the input item
		logic clr_all;   // empty both tables
		logic rd_issue;  // read table at scan index
		logic wr_en;     // write at write index from read data
		logic wr_item;   // write captured price/quantity at the count position
		logic wr_qty;    // write captured quantity at the read-back position
		logic scan_inc;  // advance scan index
		logic keep_inc;  // advance keep index
		logic cnt_set_keep; // count takes keep index
		logic cnt_inc;   // count plus one
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;  // scan index reached count
		logic hit;       // registered read price matches captured price
		logic full;      // addressed table full
		logic qty_zero;  // captured quantity is zero
	} dp_sts_t;

endpackage

`default_nettype wire

[rtl/core/oblu_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oblu_datapath: level tables and scan registers
// Holds both price/quantity memories, counts, the captured item and the
// scan/keep indexes that walk a table one entry at a time.
// ----------------------------------------------------------------------------
module oblu_datapath #(
	parameter int TABLE_DEPTH = oblu_pkg::TableDepthDefault
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire oblu_pkg::dp_cmd_t             cmd,
	output oblu_pkg::dp_sts_t                  sts,
	input  wire logic                          side,
	input  wire logic [oblu_pkg::PriceW-1:0]   price,
	input  wire logic [oblu_pkg::QtyW-1:0]     quantity,
	input  wire logic [oblu_pkg::RidxW-1:0]    read_index,
	input  wire logic                          rd_direct,
	output logic [oblu_pkg::PriceW-1:0]        rd_price,
	output logic [oblu_pkg::QtyW-1:0]          rd_qty,
	output logic [oblu_pkg::CountW-1:0]        cur_count,
	output logic                               ridx_ok
);
	import oblu_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;

	logic [PriceW-1:0] bp_mem [TABLE_DEPTH];
	logic [QtyW-1:0]   bq_mem [TABLE_DEPTH];
	logic [PriceW-1:0] ap_mem [TABLE_DEPTH];
	logic [QtyW-1:0]   aq_mem [TABLE_DEPTH];

	logic [CW-1:0] bid_cnt_q, ask_cnt_q, scan_q, keep_q, hit_pos_q;
	logic          side_q;
	logic [PriceW-1:0] price_q;
	logic [QtyW-1:0]   qty_q;
	logic [PriceW-1:0] rp_q;
	logic [QtyW-1:0]   rq_q;
	logic [CW-1:0] cnt;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [PriceW-1:0] wr_p;
	logic [QtyW-1:0]   wr_qd;
	logic [CW-1:0] ridx_ext;
	logic          wr_do;

	assign cnt = side_q ? ask_cnt_q : bid_cnt_q;
	assign ridx_ext = CW'(read_index);

	// pick read address: direct index for reads, else scan position
	assign rd_addr = rd_direct ? AW'(read_index) : scan_q[AW-1:0];

	// pick write address and data
	always_comb begin
		wr_do = cmd.wr_en | cmd.wr_item | cmd.wr_qty;
		wr_addr = keep_q[AW-1:0];
		wr_p = rp_q;
		wr_qd = rq_q;
		if (cmd.wr_item) begin
			wr_addr = cnt[AW-1:0];
			wr_p = price_q;
			wr_qd = qty_q;
		end else if (cmd.wr_qty) begin
			wr_addr = hit_pos_q[AW-1:0];
			wr_qd = qty_q;
		end
	end

	// memories: one write port, one registered read port per table
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			if ((rd_direct ? side : side_q)) begin
				rp_q <= ap_mem[rd_addr];
				rq_q <= aq_mem[rd_addr];
			end else begin
				rp_q <= bp_mem[rd_addr];
				rq_q <= bq_mem[rd_addr];
			end
		end
		if (wr_do) begin
			if (side_q) begin
				if (!cmd.wr_qty) ap_mem[wr_addr] <= wr_p;
				aq_mem[wr_addr] <= wr_qd;
			end else begin
				if (!cmd.wr_qty) bp_mem[wr_addr] <= wr_p;
				bq_mem[wr_addr] <= wr_qd;
			end
		end
	end

	// capture item payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q <= price;
			qty_q <= quantity;
		end
	end

	// counts, side and scan indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_cnt_q <= '0;
			ask_cnt_q <= '0;
			scan_q <= '0;
			keep_q <= '0;
			hit_pos_q <= '0;
			side_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				side_q <= side;
				scan_q <= '0;
				keep_q <= '0;
			end else begin
				if (cmd.scan_inc) scan_q <= scan_q + 1'b1;
				if (cmd.keep_inc) keep_q <= keep_q + 1'b1;
			end
			// remember the position of the entry whose read is in flight
			if (cmd.rd_issue && !cmd.load) hit_pos_q <= scan_q;
			if (cmd.clr_all) begin
				bid_cnt_q <= '0;
				ask_cnt_q <= '0;
			end else if (cmd.cnt_set_keep) begin
				if (side_q) ask_cnt_q <= keep_q;
				else bid_cnt_q <= keep_q;
			end else if (cmd.cnt_inc) begin
				if (side_q) ask_cnt_q <= ask_cnt_q + 1'b1;
				else bid_cnt_q <= bid_cnt_q + 1'b1;
			end
		end
	end

	assign sts.scan_end = (scan_q == cnt);
	assign sts.hit      = (rp_q == price_q);
	assign sts.full     = (cnt == CW'(TABLE_DEPTH));
	assign sts.qty_zero = (qty_q == '0);

	assign rd_price  = rp_q;
	assign rd_qty    = rq_q;
	assign cur_count = CountW'(cnt);
	assign ridx_ok   = ridx_ext < (side ? ask_cnt_q : bid_cnt_q);

	ap_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bid_cnt_q <= CW'(TABLE_DEPTH) && ask_cnt_q <= CW'(TABLE_DEPTH))
		else $error("table count beyond depth");
	ap_keep_le_scan: assert property (@(posedge clk) disable iff (!arst_n)
		keep_q <= scan_q) else $error("keep index passed scan index");
	ap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_all |=> bid_cnt_q == '0 && ask_cnt_q == '0)
		else $error("clear left entries");

endmodule

`default_nettype wire

[rtl/core/oblu_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oblu_ctrl: sequencing controller
// Checks update ids, walks the table for event levels and forms the result.
// ----------------------------------------------------------------------------
module oblu_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   action,
	input  wire logic [oblu_pkg::IdW-1:0]     first_update_id,
	input  wire logic [oblu_pkg::IdW-1:0]     final_update_id,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [2:0]                        status,
	output logic [oblu_pkg::PriceW-1:0]       level_price,
	output logic [oblu_pkg::QtyW-1:0]         level_quantity,
	output logic [oblu_pkg::CountW-1:0]       level_count,
	output oblu_pkg::dp_cmd_t                 cmd,
	input  wire oblu_pkg::dp_sts_t            sts,
	output logic                              rd_direct,
	input  wire logic [oblu_pkg::PriceW-1:0]  rd_price,
	input  wire logic [oblu_pkg::QtyW-1:0]    rd_qty,
	input  wire logic [oblu_pkg::CountW-1:0]  cur_count,
	input  wire logic                         ridx_ok
);
	import oblu_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_RM_ISSUE, S_RM_CHECK, S_UP_ISSUE, S_UP_CHECK, S_FIN
	} state_t;

	state_t state_q;
	logic [IdW-1:0] last_id_q;
	logic first_pend_q, evt_acc_q, out_valid_q, rd_ok_q;
	status_t st_q;
	logic accept, out_free;
	action_t act;
	logic snap_q, clr_q;

	assign act = action_t'(action);
	assign out_free = !out_valid_q || !out_stall;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign out_valid = out_valid_q;
	assign rd_direct = (state_q == S_IDLE);

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.load = accept;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.clr_all = (act == ACT_CLEAR);
					cmd.rd_issue = (act == ACT_READ);
				end
			end
			S_RM_ISSUE, S_UP_ISSUE: begin
				cmd.rd_issue = !sts.scan_end;
				cmd.scan_inc = !sts.scan_end;
			end
			S_RM_CHECK: begin
				if (!sts.hit) begin
					cmd.wr_en = 1'b1;
					cmd.keep_inc = 1'b1;
				end
				if (sts.scan_end) cmd.cnt_set_keep = 1'b0;
			end
			S_UP_CHECK: begin
				cmd.wr_qty = sts.hit;
			end
			S_FIN: begin
				cmd.cnt_set_keep = 1'b0;
			end
			default: ;
		endcase
		// end of removal pass: count takes kept entries
		if (state_q == S_RM_ISSUE && sts.scan_end) cmd.cnt_set_keep = 1'b1;
		// update miss at end of scan: append if room
		if (state_q == S_UP_ISSUE && sts.scan_end && !sts.full) begin
			cmd.wr_item = 1'b1;
			cmd.cnt_inc = 1'b1;
		end
		// snapshot level: append if room
		if (state_q == S_FIN && snap_q && !sts.full) begin
			cmd.wr_item = 1'b1;
			cmd.cnt_inc = 1'b1;
		end
	end

	// sequencer, id tracking and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_id_q <= '0;
			first_pend_q <= 1'b1;
			evt_acc_q <= 1'b0;
			out_valid_q <= 1'b0;
			rd_ok_q <= 1'b0;
			st_q <= ST_OK;
			level_count <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_ok_q <= 1'b0;
						st_q <= ST_OK;
						case (act)
							ACT_CLEAR: begin
								evt_acc_q <= 1'b0;
								state_q <= S_FIN;
							end
							ACT_SNAP_LVL: state_q <= S_FIN;
							ACT_SNAP_DONE: begin
								last_id_q <= final_update_id;
								first_pend_q <= 1'b1;
								evt_acc_q <= 1'b0;
								state_q <= S_FIN;
							end
							ACT_EVT_START: begin
								if (final_update_id <= last_id_q ||
								    (first_update_id != last_id_q + 1'b1 && !first_pend_q)) begin
									st_q <= ST_DROPPED;
									evt_acc_q <= 1'b0;
								end else begin
									last_id_q <= final_update_id;
									evt_acc_q <= 1'b1;
								end
								first_pend_q <= 1'b0;
								state_q <= S_FIN;
							end
							ACT_EVT_LVL: begin
								if (!evt_acc_q) begin
									st_q <= ST_IGNORED;
									state_q <= S_FIN;
								end else begin
									state_q <= S_RD;
								end
							end
							ACT_READ: begin
								rd_ok_q <= ridx_ok;
								if (!ridx_ok) st_q <= ST_RANGE;
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
						// snapshot append needs the full flag of the captured side
						if (act == ACT_SNAP_LVL) state_q <= S_FIN;
						if (act == ACT_SNAP_LVL) st_q <= ST_OK;
					end
				end
				S_RD: state_q <= sts.qty_zero ? S_RM_ISSUE : S_UP_ISSUE;
				S_RM_ISSUE: begin
					// report the count once the kept entries have landed
					if (sts.scan_end) state_q <= S_FIN;
					else state_q <= S_RM_CHECK;
				end
				S_RM_CHECK: state_q <= S_RM_ISSUE;
				S_UP_ISSUE: begin
					if (sts.scan_end) begin
						if (sts.full) st_q <= ST_FULL;
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						level_count <= sts.full ? cur_count : cur_count + 1'b1;
					end else state_q <= S_UP_CHECK;
				end
				S_UP_CHECK: begin
					if (sts.hit) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						level_count <= cur_count;
					end else state_q <= S_UP_ISSUE;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
					if (snap_q && sts.full) st_q <= ST_FULL;
					level_count <= (snap_q && !sts.full) ? cur_count + 1'b1 :
						(clr_q ? '0 : cur_count);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// remember which one-step action is finishing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= 1'b0;
			clr_q <= 1'b0;
		end else if (accept) begin
			snap_q <= (act == ACT_SNAP_LVL);
			clr_q <= (act == ACT_CLEAR);
		end
	end

	assign status = st_q;
	assign level_price = rd_ok_q ? rd_price : '0;
	assign level_quantity = rd_ok_q ? rd_qty : '0;

	ap_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !out_valid_q || $past(out_valid_q && out_stall) || state_q == S_IDLE)
		else $error("result raised before item done");
	ap_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("input taken while busy");
	ap_drop_keeps_id: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_EVT_LVL && !evt_acc_q |=> state_q == S_FIN)
		else $error("ignored level started a scan");

endmodule

`default_nettype wire

[rtl/core/order_book_level_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// order_book_level_update: bid/ask depth tables with update-id sequencing
// Keeps two unsorted level tables in insertion order and applies snapshot
// and event updates.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_stall) carries an action item; one
// output channel (out_valid/out_stall) returns exactly one result per item.
// An item is transferred when valid is high and stall is low.
// Sequencing: clear, snapshot, event start, read and ignored levels pass
// through the finishing state S_FIN before the result is raised. An event
// level walks the addressed table one entry at a time through the single
// memory read port, issuing a read and then checking it for each entry.
// One item is worked at a time; the next is taken once the result register
// is free or being emptied in the same cycle.
// Reset: counts zero, last id zero, first-event flag set; table memories are
// not cleared and hold no meaning until written.
// A stalled result holds its value; the input stays stalled meanwhile.
// ----------------------------------------------------------------------------
module order_book_level_update #(
	parameter int TABLE_DEPTH = oblu_pkg::TableDepthDefault
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   action,
	input  wire logic                         side,
	input  wire logic [oblu_pkg::PriceW-1:0]  price,
	input  wire logic [oblu_pkg::QtyW-1:0]    quantity,
	input  wire logic [oblu_pkg::IdW-1:0]     first_update_id,
	input  wire logic [oblu_pkg::IdW-1:0]     final_update_id,
	input  wire logic [oblu_pkg::RidxW-1:0]   read_index,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [2:0]                        status,
	output logic [oblu_pkg::PriceW-1:0]       level_price,
	output logic [oblu_pkg::QtyW-1:0]         level_quantity,
	output logic [oblu_pkg::CountW-1:0]       level_count
);
	import oblu_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic rd_direct, ridx_ok;
	logic [PriceW-1:0] rd_price;
	logic [QtyW-1:0] rd_qty;
	logic [CountW-1:0] cur_count;

	oblu_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .action, .first_update_id,
		.final_update_id, .out_valid, .out_stall, .status, .level_price,
		.level_quantity, .level_count, .cmd, .sts, .rd_direct, .rd_price,
		.rd_qty, .cur_count, .ridx_ok
	);

	oblu_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .side, .price, .quantity, .read_index,
		.rd_direct, .rd_price, .rd_qty, .cur_count, .ridx_ok
	);

endmodule

`default_nettype wire
